// File: src/eoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eoc_pkg;

  // extent kinds
  localparam logic [1:0] KIND_ORIG = 2'd0;
  localparam logic [1:0] KIND_SRC  = 2'd1;
  localparam logic [1:0] KIND_ZERO = 2'd2;

  // item status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic cap;        // capture input item
    logic pre1;       // align offset, clamp source offset
    logic pre2;       // available source bytes
    logic pre3;       // patch size
    logic pre4;       // patch end, used source bytes
    logic pre5;       // target size, zero tail length
    logic pass_init;  // rewind table walk
    logic wr_init;    // clear new-table writer
    logic rd;         // read entry at walk index
    logic ld;         // latch entry, compute its end
    logic a_pc;       // piece ahead of patch
    logic pad_pc;     // zero pad past old end
    logic src_pc;     // source piece
    logic zero_pc;    // zero tail of patch
    logic b_hi;       // clip start of piece behind patch
    logic b_pc;       // piece behind patch
    logic commit;     // take new table or refuse
    logic set_big;    // refuse: size too large
    logic start_wr;   // start item
    logic out_init;   // rewind result walk
    logic out_ld;     // load result register from entry
    logic out_empty;  // load empty-table result
    logic out_adv;    // result taken
  } eoc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_start;
    logic too_big;
    logic at_end;
    logic tbl_empty;
    logic out_acc;
    logic out_last;
  } eoc_sts_t;

endpackage
`default_nettype wire

// File: src/eoc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module eoc_ctrl
  import eoc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire eoc_sts_t sts,
  output eoc_cmd_t      cmd
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PRE1     = 5'd1;
  localparam logic [4:0] S_PRE2     = 5'd2;
  localparam logic [4:0] S_PRE3     = 5'd3;
  localparam logic [4:0] S_PRE4     = 5'd4;
  localparam logic [4:0] S_PRE5     = 5'd5;
  localparam logic [4:0] S_CHK      = 5'd6;
  localparam logic [4:0] S_START    = 5'd7;
  localparam logic [4:0] S_A_RD     = 5'd8;
  localparam logic [4:0] S_A_LD     = 5'd9;
  localparam logic [4:0] S_A_PC     = 5'd10;
  localparam logic [4:0] S_PAD      = 5'd11;
  localparam logic [4:0] S_SRC      = 5'd12;
  localparam logic [4:0] S_ZERO     = 5'd13;
  localparam logic [4:0] S_B_RD     = 5'd14;
  localparam logic [4:0] S_B_LD     = 5'd15;
  localparam logic [4:0] S_B_HI     = 5'd16;
  localparam logic [4:0] S_B_PC     = 5'd17;
  localparam logic [4:0] S_FIN      = 5'd18;
  localparam logic [4:0] S_OUT_RD   = 5'd19;
  localparam logic [4:0] S_OUT_LD   = 5'd20;
  localparam logic [4:0] S_OUT_WAIT = 5'd21;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_PRE1;
        end
      end
      S_PRE1: begin
        if (sts.is_start) begin
          state_next = S_START;
        end else begin
          cmd.pre1   = 1'b1;
          state_next = S_PRE2;
        end
      end
      S_PRE2: begin
        cmd.pre2   = 1'b1;
        state_next = S_PRE3;
      end
      S_PRE3: begin
        cmd.pre3   = 1'b1;
        state_next = S_PRE4;
      end
      S_PRE4: begin
        cmd.pre4   = 1'b1;
        state_next = S_PRE5;
      end
      S_PRE5: begin
        cmd.pre5   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.too_big) begin
          cmd.set_big  = 1'b1;
          cmd.out_init = 1'b1;
          state_next   = S_OUT_RD;
        end else begin
          cmd.pass_init = 1'b1;
          cmd.wr_init   = 1'b1;
          state_next    = S_A_RD;
        end
      end
      S_START: begin
        cmd.start_wr = 1'b1;
        cmd.out_init = 1'b1;
        state_next   = S_OUT_RD;
      end
      S_A_RD: begin
        if (sts.at_end) begin
          state_next = S_PAD;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_A_LD;
        end
      end
      S_A_LD: begin
        cmd.ld     = 1'b1;
        state_next = S_A_PC;
      end
      S_A_PC: begin
        cmd.a_pc   = 1'b1;
        state_next = S_A_RD;
      end
      S_PAD: begin
        cmd.pad_pc = 1'b1;
        state_next = S_SRC;
      end
      S_SRC: begin
        cmd.src_pc = 1'b1;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.zero_pc   = 1'b1;
        cmd.pass_init = 1'b1;
        state_next    = S_B_RD;
      end
      S_B_RD: begin
        if (sts.at_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_B_LD;
        end
      end
      S_B_LD: begin
        cmd.ld     = 1'b1;
        state_next = S_B_HI;
      end
      S_B_HI: begin
        cmd.b_hi   = 1'b1;
        state_next = S_B_PC;
      end
      S_B_PC: begin
        cmd.b_pc   = 1'b1;
        state_next = S_B_RD;
      end
      S_FIN: begin
        cmd.commit   = 1'b1;
        cmd.out_init = 1'b1;
        state_next   = S_OUT_RD;
      end
      S_OUT_RD: begin
        if (sts.tbl_empty) begin
          cmd.out_empty = 1'b1;
          state_next    = S_OUT_WAIT;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.out_ld = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts.out_acc) begin
          cmd.out_adv = 1'b1;
          state_next  = sts.out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/eoc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module eoc_dpath
  import eoc_pkg::*;
#(
  parameter int MAX_EXTENTS     = 16,
  parameter int SOURCE_ID_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire eoc_cmd_t                   cmd,
  output eoc_sts_t                        sts,
  input  wire logic                       mode,
  input  wire logic [31:0]                base_length,
  input  wire logic [31:0]                patch_offset,
  input  wire logic [31:0]                source_offset,
  input  wire logic [31:0]                patch_length,
  input  wire logic                       resize_flag,
  input  wire logic [SOURCE_ID_WIDTH-1:0] source_id,
  input  wire logic [31:0]                source_size,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [1:0]                      seg_kind,
  output logic [31:0]                     seg_file_offset,
  output logic [31:0]                     seg_length,
  output logic [31:0]                     seg_source_offset,
  output logic [SOURCE_ID_WIDTH-1:0]      seg_source_id,
  output logic                            seg_valid,
  output logic [31:0]                     file_size,
  output logic                            last
);

  localparam int IW    = $clog2(MAX_EXTENTS);
  localparam int CW    = $clog2(MAX_EXTENTS + 1);
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int SW    = SOURCE_ID_WIDTH;

  // table memory, two banks: live table and the one being built
  logic [1:0]    mem_kind [DEPTH];
  logic [31:0]   mem_len  [DEPTH];
  logic [31:0]   mem_src  [DEPTH];
  logic [SW-1:0] mem_id   [DEPTH];

  logic          bank;
  logic [CW-1:0] count;
  logic [31:0]   cur;

  // captured item
  logic          c_mode;
  logic [31:0]   c_base;
  logic [31:0]   c_po;
  logic [31:0]   c_so;
  logic [31:0]   c_plen;
  logic          c_resize;
  logic [SW-1:0] c_sid;
  logic [31:0]   c_ss;

  // derived patch values
  logic [31:0] ps;
  logic [31:0] eo;
  logic [31:0] avail;
  logic [31:0] psize;
  logic [31:0] use_len;
  logic [31:0] zlen;
  logic [32:0] pe;
  logic [32:0] target;

  // table walk
  logic [CW-1:0] idx;
  logic [32:0]   s;
  logic [32:0]   e;
  logic [32:0]   hi;
  logic [31:0]   dlt;
  logic [1:0]    ent_kind;
  logic [31:0]   ent_src;
  logic [SW-1:0] ent_id;

  // read port
  logic [1:0]    rd_kind;
  logic [31:0]   rd_len;
  logic [31:0]   rd_src;
  logic [SW-1:0] rd_id;

  // pending piece and new-table writer
  logic          pc_vld;
  logic [1:0]    pc_kind;
  logic [31:0]   pc_len;
  logic [31:0]   pc_src;
  logic [SW-1:0] pc_id;
  logic [CW-1:0] wcnt;
  logic [32:0]   woff;
  logic          ovf;

  logic [31:0]   ooff;

  logic [32:0]   room;
  logic          fits;
  logic [31:0]   tlen;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_kind;
  logic [31:0]   wr_len;
  logic [31:0]   wr_src;
  logic [SW-1:0] wr_id;

  assign sts.is_start  = ~c_mode;
  assign sts.too_big   = target[32];
  assign sts.at_end    = (idx == count);
  assign sts.tbl_empty = (count == '0);
  assign sts.out_acc   = out_valid & ~out_stall;
  assign sts.out_last  = last;

  // truncation of the pending piece to the target size
  assign room = target - woff;
  assign fits = (woff < target);
  assign tlen = ({1'b0, pc_len} > room) ? room[31:0] : pc_len;

  // single write port: start item or a piece of the new table
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {~bank, wcnt[IW-1:0]};
    wr_kind = pc_kind;
    wr_len  = tlen;
    wr_src  = pc_src;
    wr_id   = pc_id;
    if (cmd.start_wr) begin
      wr_en   = (c_base != 32'd0);
      wr_addr = {bank, {IW{1'b0}}};
      wr_kind = KIND_ORIG;
      wr_len  = c_base;
      wr_src  = 32'd0;
      wr_id   = '0;
    end else if (pc_vld && fits && (wcnt != CW'(MAX_EXTENTS))) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_kind[wr_addr] <= wr_kind;
      mem_len[wr_addr]  <= wr_len;
      mem_src[wr_addr]  <= wr_src;
      mem_id[wr_addr]   <= wr_id;
    end
    if (cmd.rd) begin
      rd_kind <= mem_kind[{bank, idx[IW-1:0]}];
      rd_len  <= mem_len[{bank, idx[IW-1:0]}];
      rd_src  <= mem_src[{bank, idx[IW-1:0]}];
      rd_id   <= mem_id[{bank, idx[IW-1:0]}];
    end
  end

  // item capture and patch arithmetic
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      c_mode   <= mode;
      c_base   <= base_length;
      c_po     <= patch_offset;
      c_so     <= source_offset;
      c_plen   <= patch_length;
      c_resize <= resize_flag;
      c_sid    <= source_id;
      c_ss     <= source_size;
    end
    if (cmd.pre1) begin
      ps <= {c_po[31:2], 2'b00};
      eo <= (c_so > c_ss) ? c_ss : c_so;
    end
    if (cmd.pre2) begin
      avail <= c_ss - eo;
    end
    if (cmd.pre3) begin
      psize <= (c_plen == 32'd0) ? avail : c_plen;
    end
    if (cmd.pre4) begin
      pe      <= {1'b0, ps} + {1'b0, psize};
      use_len <= (psize < avail) ? psize : avail;
    end
    if (cmd.pre5) begin
      target <= c_resize ? pe : (({1'b0, cur} > pe) ? {1'b0, cur} : pe);
      zlen   <= psize - use_len;
    end
  end

  // walk over the live table
  always_ff @(posedge clk) begin
    if (cmd.pass_init || cmd.out_init) begin
      idx <= '0;
      s   <= '0;
    end else if (cmd.a_pc || cmd.b_pc || cmd.out_adv) begin
      idx <= idx + CW'(1);
      s   <= e;
    end
    if (cmd.ld) begin
      e        <= s + {1'b0, rd_len};
      ent_kind <= rd_kind;
      ent_src  <= rd_src;
      ent_id   <= rd_id;
    end
    if (cmd.b_hi) begin
      hi  <= (s >= pe) ? s : pe;
      dlt <= (s >= pe) ? 32'd0 : 32'(pe - s);
    end
  end

  // piece producers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc_vld <= 1'b0;
    end else begin
      pc_vld <= 1'b0;
      if (cmd.a_pc) begin
        pc_vld <= (s < {1'b0, ps});
      end else if (cmd.pad_pc) begin
        pc_vld <= (ps > cur);
      end else if (cmd.src_pc) begin
        pc_vld <= (use_len != 32'd0);
      end else if (cmd.zero_pc) begin
        pc_vld <= (zlen != 32'd0);
      end else if (cmd.b_pc) begin
        pc_vld <= (e > pe);
      end
    end
    if (cmd.a_pc) begin
      pc_kind <= ent_kind;
      pc_len  <= 32'(((e < {1'b0, ps}) ? e : {1'b0, ps}) - s);
      pc_src  <= ent_src;
      pc_id   <= ent_id;
    end else if (cmd.pad_pc) begin
      pc_kind <= KIND_ZERO;
      pc_len  <= ps - cur;
      pc_src  <= 32'd0;
      pc_id   <= '0;
    end else if (cmd.src_pc) begin
      pc_kind <= KIND_SRC;
      pc_len  <= use_len;
      pc_src  <= eo;
      pc_id   <= c_sid;
    end else if (cmd.zero_pc) begin
      pc_kind <= KIND_ZERO;
      pc_len  <= zlen;
      pc_src  <= 32'd0;
      pc_id   <= '0;
    end else if (cmd.b_pc) begin
      pc_kind <= ent_kind;
      pc_len  <= 32'(e - hi);
      pc_src  <= (ent_kind == KIND_SRC) ? (ent_src + dlt) : 32'd0;
      pc_id   <= ent_id;
    end
  end

  // new-table writer bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
      woff <= '0;
      ovf  <= 1'b0;
    end else if (cmd.wr_init) begin
      wcnt <= '0;
      woff <= '0;
      ovf  <= 1'b0;
    end else if (pc_vld) begin
      woff <= woff + {1'b0, pc_len};
      if (fits) begin
        if (wcnt == CW'(MAX_EXTENTS)) begin
          ovf <= 1'b1;
        end else begin
          wcnt <= wcnt + CW'(1);
        end
      end
    end
  end

  // live table state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
      cur   <= 32'd0;
    end else if (cmd.start_wr) begin
      count <= (c_base != 32'd0) ? CW'(1) : '0;
      cur   <= c_base;
    end else if (cmd.commit && !ovf) begin
      bank  <= ~bank;
      count <= wcnt;
      cur   <= target[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_wr) begin
      status <= ST_OK;
    end else if (cmd.set_big) begin
      status <= ST_TOO_BIG;
    end else if (cmd.commit) begin
      status <= ovf ? ST_FULL : ST_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld || cmd.out_empty) begin
      out_valid <= 1'b1;
    end else if (cmd.out_adv) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_init) begin
      ooff <= 32'd0;
    end else if (cmd.out_adv) begin
      ooff <= ooff + seg_length;
    end
    if (cmd.out_ld) begin
      seg_kind          <= rd_kind;
      seg_file_offset   <= ooff;
      seg_length        <= rd_len;
      seg_source_offset <= rd_src;
      seg_source_id     <= rd_id;
      seg_valid         <= 1'b1;
      file_size         <= cur;
      last              <= ((idx + CW'(1)) == count);
    end else if (cmd.out_empty) begin
      seg_kind          <= KIND_ORIG;
      seg_file_offset   <= 32'd0;
      seg_length        <= 32'd0;
      seg_source_offset <= 32'd0;
      seg_source_id     <= '0;
      seg_valid         <= 1'b0;
      file_size         <= cur;
      last              <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: src/extent_overlay_composer.sv
// Channel  Handshake           Payload
// in       in_valid/in_stall   mode, base_length, patch_offset, source_offset,
//                              patch_length, resize_flag, source_id, source_size
// out      out_valid/out_stall status, seg_kind, seg_file_offset, seg_length,
//                              seg_source_offset, seg_source_id, seg_valid,
//                              file_size, last
//
// One item at a time; in_stall is high from acceptance until the last result is taken.
// A start item needs no table walk; a patch item walks the live table twice through one
// registered memory read port. Each result is read, loaded into the result register
// and then held while out_stall is high.
// Synchronous reset empties the table and zeroes the file size.
`timescale 1ns / 1ps
`default_nettype none
module extent_overlay_composer
  import eoc_pkg::*;
#(
  parameter int MAX_EXTENTS     = 16,
  parameter int SOURCE_ID_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       mode,
  input  wire logic [31:0]                base_length,
  input  wire logic [31:0]                patch_offset,
  input  wire logic [31:0]                source_offset,
  input  wire logic [31:0]                patch_length,
  input  wire logic                       resize_flag,
  input  wire logic [SOURCE_ID_WIDTH-1:0] source_id,
  input  wire logic [31:0]                source_size,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [1:0]                      seg_kind,
  output logic [31:0]                     seg_file_offset,
  output logic [31:0]                     seg_length,
  output logic [31:0]                     seg_source_offset,
  output logic [SOURCE_ID_WIDTH-1:0]      seg_source_id,
  output logic                            seg_valid,
  output logic [31:0]                     file_size,
  output logic                            last
);

  eoc_cmd_t cmd;
  eoc_sts_t sts;

  // sequencer
  eoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory and arithmetic
  eoc_dpath #(
    .MAX_EXTENTS     (MAX_EXTENTS),
    .SOURCE_ID_WIDTH (SOURCE_ID_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .mode              (mode),
    .base_length       (base_length),
    .patch_offset      (patch_offset),
    .source_offset     (source_offset),
    .patch_length      (patch_length),
    .resize_flag       (resize_flag),
    .source_id         (source_id),
    .source_size       (source_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .seg_kind          (seg_kind),
    .seg_file_offset   (seg_file_offset),
    .seg_length        (seg_length),
    .seg_source_offset (seg_source_offset),
    .seg_source_id     (seg_source_id),
    .seg_valid         (seg_valid),
    .file_size         (file_size),
    .last              (last)
  );

endmodule
`default_nettype wire
